@@ rtl/lpfd_pkg.sv @@
// ----------------------------------------------------------------------------
// lpfd_pkg: shared definitions for the length-prefixed frame deframer
// Constants, result kinds and the result record passed between the parser
// and the top level.
// ----------------------------------------------------------------------------
package lpfd_pkg;

    // Register map
    localparam int unsigned CFG_ADDR_W      = 3;
    localparam logic        REG_IDX_MAX_LEN = 1'b0;
    localparam logic [31:0] MAX_LEN_RESET   = 32'd10485760;

    // Header layout
    localparam logic [31:0] HEADER_BYTES = 32'd8;
    localparam logic [3:0]  POS_LEN_LAST = 4'd3;
    localparam logic [3:0]  POS_CMD_LAST = 4'd7;
    localparam logic [3:0]  POS_BODY     = 4'd8;

    typedef enum logic [1:0] {
        KIND_BODY  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         body_byte;
        logic signed [31:0] command_id;
        logic [31:0]        packet_length;
        logic               last;
    } result_t;

endpackage

@@ rtl/lpfd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lpfd_cfg_regs: configuration register file
// APB-style slave holding the maximum packet length.
// ----------------------------------------------------------------------------
module lpfd_cfg_regs
    import lpfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [31:0]           max_len
);

    logic        wr_en;
    logic [31:0] max_len_reg;

    // Decode a completed write to the maximum length register
    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_IDX_MAX_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (wr_en)
        begin
            max_len_reg <= pwdata;
        end
    end

    // Read back; no wait states
    assign prdata  = (paddr[2] == REG_IDX_MAX_LEN) ? max_len_reg : 32'd0;
    assign pready  = 1'b1;
    assign max_len = max_len_reg;

endmodule

@@ rtl/lpfd_parser.sv @@
// ----------------------------------------------------------------------------
// lpfd_parser: header and body tracker
// Consumes one byte per step, assembles the header and produces at most
// one result per byte. Goes dead after a malformed length.
// ----------------------------------------------------------------------------
module lpfd_parser
    import lpfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] max_len,
    output logic        res_valid,
    output result_t     res,
    output logic        dead
);

    logic [3:0]  pos_reg,  pos_next;
    logic [31:0] len_reg,  len_next;
    logic [31:0] cmd_reg,  cmd_next;
    logic [31:0] rem_reg,  rem_next;
    logic        dead_reg, dead_next;

    // Work out the next state and the result for this byte
    always_comb
    begin
        logic [3:0]  pos;
        logic [31:0] len_new;
        logic [31:0] cmd_new;
        logic [31:0] rem_dec;
        logic [31:0] body_len;

        pos_next  = pos_reg;
        len_next  = len_reg;
        cmd_next  = cmd_reg;
        rem_next  = rem_reg;
        dead_next = dead_reg;
        res_valid = 1'b0;
        res       = '{kind: KIND_BODY, body_byte: 8'd0, command_id: 32'sd0,
                      packet_length: 32'd0, last: 1'b0};

        pos      = ((pos_reg >= POS_BODY) && (rem_reg == 32'd0)) ? 4'd0 : pos_reg;
        len_new  = {len_reg[23:0], rx_byte};
        cmd_new  = {cmd_reg[23:0], rx_byte};
        rem_dec  = rem_reg - 32'd1;
        body_len = len_reg - HEADER_BYTES;

        if (step && !dead_reg)
        begin
            pos_next = pos;
            if (pos >= POS_BODY)
            begin
                // Body byte: emit and count down
                rem_next  = rem_dec;
                res_valid = 1'b1;
                res       = '{kind: KIND_BODY, body_byte: rx_byte,
                              command_id: signed'(cmd_reg),
                              packet_length: len_reg, last: (rem_dec == 32'd0)};
                if (rem_dec == 32'd0)
                begin
                    pos_next = 4'd0;
                end
            end
            else if (pos <= POS_LEN_LAST)
            begin
                // Length bytes; check the length on the last one
                len_next = len_new;
                if ((pos == POS_LEN_LAST) &&
                    ((len_new < HEADER_BYTES) || (len_new > max_len)))
                begin
                    dead_next = 1'b1;
                    res_valid = 1'b1;
                    res       = '{kind: KIND_ERROR, body_byte: 8'd0,
                                  command_id: 32'sd0,
                                  packet_length: len_new, last: 1'b1};
                end
                else
                begin
                    pos_next = pos + 4'd1;
                end
            end
            else
            begin
                // Command id bytes; start the body on the last one
                cmd_next = cmd_new;
                if (pos == POS_CMD_LAST)
                begin
                    rem_next = body_len;
                    if (body_len == 32'd0)
                    begin
                        pos_next  = 4'd0;
                        res_valid = 1'b1;
                        res       = '{kind: KIND_EMPTY, body_byte: 8'd0,
                                      command_id: signed'(cmd_new),
                                      packet_length: len_reg, last: 1'b1};
                    end
                    else
                    begin
                        pos_next = POS_BODY;
                    end
                end
                else
                begin
                    pos_next = pos + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 4'd0;
            len_reg  <= 32'd0;
            cmd_reg  <= 32'd0;
            rem_reg  <= 32'd0;
            dead_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            cmd_reg  <= cmd_next;
            rem_reg  <= rem_next;
            dead_reg <= dead_next;
        end
    end

    assign dead = dead_reg;

endmodule

@@ rtl/length_prefixed_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer: byte stream to packet body deframer
// Splits a stream of length-prefixed packets into tagged body bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) takes one received byte per
//   request. Each packet is an 8-byte big-endian header (32-bit total length,
//   32-bit signed command id) followed by the body.
//   Output channel (out_valid / out_stall / result fields) carries one request
//   per body byte, one per empty-body packet, and one for a bad length.
//   After a bad length the block drops every byte until reset.
//   The APB port holds max_packet_length at address 0 (reset 10485760).
// Timing:
//   One byte per cycle sustained while the receiver does not stall. A byte is
//   registered at the input, parsed from there and its result lands in the
//   output register, which presents it until it is taken. Header bytes give
//   no result, but for a bad length and for a packet with an empty body.
//   When the receiver stalls, the output register holds; an empty input
//   register still takes one more byte, then in_stall rises until the output
//   drains.
//   Reset clears the parser state, restores the default maximum and empties
//   both registers.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer
    import lpfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // byte input
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            rx_byte,
    // result output
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            result_kind,
    output logic [7:0]            body_byte,
    output logic signed [31:0]    command_id,
    output logic [31:0]           packet_length,
    output logic                  last_of_packet,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg;
    logic        advance;
    logic        step;
    logic        res_valid;
    result_t     res;
    logic        dead;
    logic [31:0] max_len;

    lpfd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    lpfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .max_len   (max_len),
        .res_valid (res_valid),
        .res       (res),
        .dead      (dead)
    );

    // Advance the parse stage unless a result is held by the receiver
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    // Input register: load on accept, drain on advance
    always_comb
    begin
        if (in_valid && !in_stall)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    assign out_valid_next = advance ? (step && res_valid) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = out_res_reg.kind;
    assign body_byte      = out_res_reg.body_byte;
    assign command_id     = out_res_reg.command_id;
    assign packet_length  = out_res_reg.packet_length;
    assign last_of_packet = out_res_reg.last;

    // A dead link produces nothing more
    assert property (@(posedge clk) disable iff (!rst_n)
        (dead && step) |-> !res_valid)
        else $error("result produced after link went dead");

    // An error result always closes its packet and kills the link
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid && (res.kind == KIND_ERROR)) |=> (dead && out_res_reg.last))
        else $error("error result without dead link or last flag");

    // A held result is never dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result lost");

endmodule

@@ bench/lpfd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfd_checker: result predictor and scoreboard for the frame deframer
// Watches the byte channel, the result channel and configuration writes,
// keeps its own copy of the header parser state and compares every result
// request against the oldest predicted one.
// ----------------------------------------------------------------------------
module lpfd_checker
    import lpfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [7:0]            rx_byte,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [1:0]            result_kind,
    input  logic [7:0]            body_byte,
    input  logic signed [31:0]    command_id,
    input  logic [31:0]           packet_length,
    input  logic                  last_of_packet,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    outstanding
);

    localparam logic [CFG_ADDR_W-1:0] MAX_LEN_ADDR = {REG_IDX_MAX_LEN, 2'b00};
    localparam int MAX_REPORTS = 10;

    // predicted results still waiting for their request
    result_t frame_results_q[$];

    // shadow of the parser state and the length limit
    logic [31:0] len_limit;
    logic [3:0]  hdr_pos;
    logic [31:0] len_acc;
    logic [31:0] cmd_acc;
    logic [31:0] body_left;
    logic        link_down;

    // advance the shadow parser by one byte and queue any result it gives
    task parse_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        if (link_down)
            return;
        if (hdr_pos >= POS_BODY && body_left == 32'd0)
            hdr_pos = '0;
        if (hdr_pos >= POS_BODY) begin
            body_left = body_left - 32'd1;
            r.kind = KIND_BODY;
            r.body_byte = b;
            r.command_id = cmd_acc;
            r.packet_length = len_acc;
            r.last = (body_left == 32'd0);
            frame_results_q.push_back(r);
            if (body_left == 32'd0)
                hdr_pos = '0;
        end
        else if (hdr_pos <= POS_LEN_LAST) begin
            len_acc = {len_acc[23:0], b};
            if (hdr_pos == POS_LEN_LAST
                && (len_acc < HEADER_BYTES || len_acc > len_limit)) begin
                // bad length: report once, then drop everything
                link_down = 1'b1;
                r.kind = KIND_ERROR;
                r.packet_length = len_acc;
                r.last = 1'b1;
                frame_results_q.push_back(r);
            end
            else begin
                hdr_pos = hdr_pos + 4'd1;
            end
        end
        else begin
            cmd_acc = {cmd_acc[23:0], b};
            if (hdr_pos == POS_CMD_LAST) begin
                body_left = len_acc - HEADER_BYTES;
                if (body_left == 32'd0) begin
                    hdr_pos = '0;
                    r.kind = KIND_EMPTY;
                    r.command_id = cmd_acc;
                    r.packet_length = len_acc;
                    r.last = 1'b1;
                    frame_results_q.push_back(r);
                end
                else begin
                    hdr_pos = POS_BODY;
                end
            end
            else begin
                hdr_pos = hdr_pos + 4'd1;
            end
        end
    endtask

    // compare one result request against the oldest prediction
    task check_result;
        result_t want;
        logic    bad;
        if (frame_results_q.size() == 0) begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: unexpected result kind %0d byte %h cmd %0d len %0d last %b",
                         $realtime, result_kind, body_byte, command_id, packet_length,
                         last_of_packet);
            fail_count++;
            return;
        end
        want = frame_results_q.pop_front();
        bad = (want.kind != kind_t'(result_kind)) || (want.body_byte != body_byte)
              || (want.command_id != command_id) || (want.packet_length != packet_length)
              || (want.last != last_of_packet);
        if (bad) begin
            if (fail_count < MAX_REPORTS) begin
                $display("%0t: result mismatch", $realtime);
                $display("    expected kind %0d byte %h cmd %0d len %0d last %b",
                         want.kind, want.body_byte, want.command_id, want.packet_length,
                         want.last);
                $display("    actual   kind %0d byte %h cmd %0d len %0d last %b",
                         result_kind, body_byte, command_id, packet_length, last_of_packet);
            end
            fail_count++;
        end
    endtask

    // sample all three ports on the rising edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            len_limit = MAX_LEN_RESET;
            hdr_pos = '0;
            len_acc = '0;
            cmd_acc = '0;
            body_left = '0;
            link_down = 1'b0;
            frame_results_q.delete();
            outstanding = 0;
            fail_count = 0;
        end
        else begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                parse_byte(rx_byte);
            // the block ignores writes with address bit 2 set; only address 0 is tracked here
            if (psel && penable && pwrite && pready && paddr == MAX_LEN_ADDR)
                len_limit = pwdata;
            outstanding = frame_results_q.size();
        end
    end

endmodule

@@ bench/length_prefixed_frame_deframer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_tb: stimulus and verdict for the deframer
// Streams directed and random length-prefixed packets through the block
// under several length limits with random idling on both channels, ends
// with a bad length and a dead link, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_tb;
    import lpfd_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] MAX_LEN_ADDR = {REG_IDX_MAX_LEN, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR   = {~REG_IDX_MAX_LEN, 2'b00};
    localparam int IDLE_PCT    = 37;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_BYTES = 130;
    localparam int PIPE_CYCLES = 4;
    localparam int TAIL_CYCLES = 8;
    localparam int STALL_LIMIT = 1000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            rx_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [1:0]            result_kind;
    logic [7:0]            body_byte;
    logic signed [31:0]    command_id;
    logic [31:0]           packet_length;
    logic                  last_of_packet;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int          fail_count;
    int          outstanding;
    int          sent_bytes;
    int          quiet_cycles;
    logic        calm;
    logic [31:0] cur_max;

    length_prefixed_frame_deframer uut (.*);

    lpfd_checker chk (
        .clk, .rst_n, .in_valid, .in_stall, .rx_byte, .out_valid, .out_stall,
        .result_kind, .body_byte, .command_id, .packet_length, .last_of_packet,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .fail_count, .outstanding
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // random receiver stalls, none during the calm stretch
    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99, 0) < IDLE_PCT);
    end

    // abort when no request moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offer one byte, with a random gap first, and hold it until taken
    task push_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (in_stall);
        sent_bytes++;
        @(negedge clk);
    endtask

    task push_word(input logic [31:0] w);
        int i;
        for (i = 3; i >= 0; i--)
            push_byte(w[8*i +: 8]);
    endtask

    // hold the sender until every result is out and the pipe is empty
    task settle_idle;
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (PIPE_CYCLES) @(negedge clk);
    endtask

    task cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task retune(input logic [31:0] val);
        settle_idle();
        cfg_write(MAX_LEN_ADDR, val);
        cur_max = val;
    endtask

    // mostly short bodies, now and then a longer one or one at the limit
    function automatic logic [31:0] pick_len(input logic [31:0] lim);
        logic [31:0] body;
        body = ($urandom_range(19, 0) == 0) ? $urandom_range(100, 16) : $urandom_range(12, 0);
        if (lim - HEADER_BYTES < body)
            body = lim - HEADER_BYTES;
        if ($urandom_range(9, 0) == 0 && lim - HEADER_BYTES <= 100)
            body = lim - HEADER_BYTES;
        return body + HEADER_BYTES;
    endfunction

    function automatic logic [31:0] pick_cmd();
        case ($urandom_range(9, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // send one packet; a non-zero cut changes the limit after that many
    // header bytes
    task send_packet(input logic [31:0] len, input logic [31:0] cmd, input int cut,
                     input logic [31:0] new_max);
        logic [63:0] hdr;
        int          i;
        int          n;
        hdr = {len, cmd};
        for (i = 0; i < 8; i++) begin
            if (cut != 0 && i == cut)
                retune(new_max);
            push_byte(hdr[63 - 8*i -: 8]);
        end
        for (n = 0; n < int'(len - HEADER_BYTES); n++)
            push_byte($urandom_range(255, 0));
    endtask

    initial
    begin
        int          p;
        int          cut;
        int          phase_start;
        logic [31:0] next_max;
        logic [31:0] len;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        cur_max = MAX_LEN_RESET;
        sent_bytes = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: a write to an unused address must not touch the limit,
        // then empty and short packets with extreme command ids and bytes
        cfg_write(SPARE_ADDR, 32'd7);
        push_word(HEADER_BYTES);
        push_word(32'h8000_0000);
        push_word(32'd10);
        push_word(32'h7fff_ffff);
        push_byte(8'hff);
        push_byte(8'h00);
        push_word(HEADER_BYTES);
        push_word(32'hffff_ffff);

        // random packets under a series of limits; a malformed length kills
        // the link for good, so the stream stays well formed here
        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       next_max = cur_max;
                1:       next_max = HEADER_BYTES;
                2:       next_max = 32'hffff_ffff;
                3:       next_max = $urandom_range(60, 9);
                4:       next_max = $urandom() | 32'h100;
                default: next_max = MAX_LEN_RESET;
            endcase
            calm = (p == 2);
            if (p != 0) begin
                if ($urandom_range(1, 0)) begin
                    // change the limit part way through a header
                    cut = $urandom_range(7, 1);
                    len = pick_len((cur_max < next_max) ? cur_max : next_max);
                    send_packet(len, pick_cmd(), cut, next_max);
                end
                else
                    retune(next_max);
            end
            phase_start = sent_bytes;
            while (sent_bytes - phase_start < PHASE_BYTES)
                send_packet(pick_len(cur_max), pick_cmd(), 0, '0);
        end
        calm = 1'b0;

        // finish with a bad length, short or over the limit, then noise
        if ($urandom_range(1, 0)) begin
            len = $urandom_range(7, 0);
        end
        else begin
            next_max = $urandom_range(1000, 8);
            retune(next_max);
            len = $urandom_range(1, 0) ? next_max + 1 : 32'hffff_ffff;
        end
        push_word(len);
        push_word(pick_cmd());
        repeat (20) push_byte($urandom_range(255, 0));

        settle_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
